>>> src/crc8sr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the status frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package crc8sr_pkg;

    localparam int FRAME_BYTES = 20;
    localparam int PAYLOAD_LEN = FRAME_BYTES - 3;
    localparam int POS_W       = 5;
    localparam int CFG_IDX_W   = 8;

    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] STATUS_KIND_RST  = 8'h02;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_KIND  = 8'd1;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } t_phase;

    // Frame end event from the parser to the status block.
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [31:0] front_left;
        logic [31:0] front_right;
        logic [31:0] rear_left;
        logic [31:0] rear_right;
        logic [7:0]  flags;
    } t_frame_evt;

    // CRC-8, poly 0x07, MSB first, one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crc8_status_frame_receiver_core.sv
// Top level of the CRC-8 status frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per transfer and hunts for a 20-byte status
// frame: start marker, type byte, four little-endian 32-bit angle words
// (front-left, front-right, rear-left, rear-right), a flags byte and a CRC-8
// byte (poly 0x07, init 0x00, MSB first, over bytes 0..18). A type byte that
// does not match sends the parser back to hunting, and that byte is not
// retried as a start marker. Each CRC byte yields exactly one result
// transfer: frame_ok plus the held status, which a good frame updates and a
// bad frame leaves alone, and the wrapping good/bad frame counters.
// Rate: one byte per clock. Bytes are taken every cycle; only a CRC byte
// waits, and only while the previous result is still held and not being
// taken, since the result register is the single output slot. The result
// is registered and appears in the cycle after its CRC byte is transferred.
// The start marker (index 0, reset 0xAA) and the status type code (index 1,
// reset 0x02) are written through the configuration channel, which is always
// ready; writes to other indexes are ignored.

module crc8_status_frame_receiver_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [crc8sr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    // byte input channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [7:0]                        i_rx_byte,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_frame_ok,
    output logic [31:0]                            o_front_left_word,
    output logic [31:0]                            o_front_right_word,
    output logic [31:0]                            o_rear_left_word,
    output logic [31:0]                            o_rear_right_word,
    output logic [7:0]                             o_status_flags,
    output logic [31:0]                            o_good_frames,
    output logic [31:0]                            o_bad_frames
);
    import crc8sr_pkg::*;

    logic [7:0] r_start_marker;
    logic [7:0] r_status_kind;
    logic       in_accept;
    logic       at_crc;
    t_frame_evt evt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_status_kind  <= STATUS_KIND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_STATUS_KIND:  r_status_kind  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Only the CRC byte needs the result slot; held values stay put until
    // the slot is drained, so they drive the result ports directly.
    assign o_ready   = !at_crc || !o_valid || i_ready;
    assign in_accept = i_valid && o_ready;

    crc8sr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_status_kind  (r_status_kind),
        .o_at_crc       (at_crc),
        .o_evt          (evt)
    );

    crc8sr_status u_status (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_evt              (evt),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_frame_ok         (o_frame_ok),
        .o_front_left_word  (o_front_left_word),
        .o_front_right_word (o_front_right_word),
        .o_rear_left_word   (o_rear_left_word),
        .o_rear_right_word  (o_rear_right_word),
        .o_status_flags     (o_status_flags),
        .o_good_frames      (o_good_frames),
        .o_bad_frames       (o_bad_frames)
    );

endmodule

`default_nettype wire

>>> src/crc8sr_parser.sv
// Frame parser: phase machine, running CRC and payload shift line.
`timescale 1ns / 1ps
`default_nettype none

module crc8sr_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [7:0]           i_start_marker,
    input  wire logic [7:0]           i_status_kind,
    output logic                      o_at_crc,
    output crc8sr_pkg::t_frame_evt    o_evt
);
    import crc8sr_pkg::*;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 2);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic             n_shift;
    logic [7:0]       r_pay [PAYLOAD_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
        end
    end

    // Payload bytes shift in at the top; byte j of the payload lands at r_pay[j].
    always_ff @(posedge i_clk) begin
        if (n_shift) begin
            for (int i = 0; i < PAYLOAD_LEN - 1; i++) begin
                r_pay[i] <= r_pay[i+1];
            end
            r_pay[PAYLOAD_LEN-1] <= i_rx_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_shift = 1'b0;
        o_evt   = '0;
        o_evt.front_left  = {r_pay[3],  r_pay[2],  r_pay[1],  r_pay[0]};
        o_evt.front_right = {r_pay[7],  r_pay[6],  r_pay[5],  r_pay[4]};
        o_evt.rear_left   = {r_pay[11], r_pay[10], r_pay[9],  r_pay[8]};
        o_evt.rear_right  = {r_pay[15], r_pay[14], r_pay[13], r_pay[12]};
        o_evt.flags       = r_pay[PAYLOAD_LEN-1];
        if (i_accept) begin
            case (r_phase)
                PH_START: begin
                    if (i_rx_byte == i_start_marker) begin
                        n_crc   = crc8_byte(CRC_INIT, i_rx_byte);
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    // a wrong type byte is dropped, not retried as a start byte
                    if (i_rx_byte == i_status_kind) begin
                        n_crc   = crc8_byte(r_crc, i_rx_byte);
                        n_pos   = POS_FIRST;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_PAYLOAD: begin
                    n_shift = 1'b1;
                    n_crc   = crc8_byte(r_crc, i_rx_byte);
                    n_pos   = r_pos + POS_W'(1);
                    if (r_pos == POS_LAST) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    o_evt.done = 1'b1;
                    o_evt.ok   = (i_rx_byte == r_crc);
                    n_pos      = '0;
                    n_phase    = PH_START;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    assign o_at_crc = (r_phase == PH_CRC);

endmodule

`default_nettype wire

>>> src/crc8sr_status.sv
// Held status, frame counters and result valid register.
`timescale 1ns / 1ps
`default_nettype none

module crc8sr_status (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire crc8sr_pkg::t_frame_evt i_evt,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output logic                      o_frame_ok,
    output logic [31:0]               o_front_left_word,
    output logic [31:0]               o_front_right_word,
    output logic [31:0]               o_rear_left_word,
    output logic [31:0]               o_rear_right_word,
    output logic [7:0]                o_status_flags,
    output logic [31:0]               o_good_frames,
    output logic [31:0]               o_bad_frames
);
    import crc8sr_pkg::*;

    logic        r_valid;
    logic        r_ok;
    logic [31:0] r_fl, r_fr, r_rl, r_rr;
    logic [7:0]  r_flags;
    logic [31:0] r_good, r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            r_fl    <= '0;
            r_fr    <= '0;
            r_rl    <= '0;
            r_rr    <= '0;
            r_flags <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            if (i_evt.done) begin
                r_valid <= 1'b1;
                r_ok    <= i_evt.ok;
                if (i_evt.ok) begin
                    r_fl    <= i_evt.front_left;
                    r_fr    <= i_evt.front_right;
                    r_rl    <= i_evt.rear_left;
                    r_rr    <= i_evt.rear_right;
                    r_flags <= i_evt.flags;
                    r_good  <= r_good + 32'd1;
                end else begin
                    r_bad   <= r_bad + 32'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_frame_ok         = r_ok;
    assign o_front_left_word  = r_fl;
    assign o_front_right_word = r_fr;
    assign o_rear_left_word   = r_rl;
    assign o_rear_right_word  = r_rr;
    assign o_status_flags     = r_flags;
    assign o_good_frames      = r_good;
    assign o_bad_frames       = r_bad;

endmodule

`default_nettype wire

>>> test/crc8_status_frame_checker.sv
// Frame CRC helper and result checker for the CRC-8 status frame receiver testbench.
`timescale 1ns / 1ps

package crc8sr_tb_pkg;

    import crc8sr_pkg::*;

    // One result transfer, fields in port order.
    typedef struct packed {
        logic        frame_ok;
        logic [31:0] front_left;
        logic [31:0] front_right;
        logic [31:0] rear_left;
        logic [31:0] rear_right;
        logic [7:0]  flags;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } t_status_result;

    // CRC-8 over one more byte, poly 0x07, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

module crc8_status_frame_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_ready,
    input  wire logic [crc8sr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic [7:0]                        i_rx_byte,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic                              i_frame_ok,
    input  wire logic [31:0]                       i_front_left_word,
    input  wire logic [31:0]                       i_front_right_word,
    input  wire logic [31:0]                       i_rear_left_word,
    input  wire logic [31:0]                       i_rear_right_word,
    input  wire logic [7:0]                        i_status_flags,
    input  wire logic [31:0]                       i_good_frames,
    input  wire logic [31:0]                       i_bad_frames,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_results,
    output int                                     o_good_seen,
    output int                                     o_bad_seen
);

    import crc8sr_pkg::*;
    import crc8sr_tb_pkg::*;

    localparam int MAX_REPORTS = 10;

    // predicted parser and status state
    t_phase      phase;
    logic [4:0]  pos;
    logic [7:0]  crc_acc;
    logic [7:0]  frame_store [PAYLOAD_LEN];
    logic [31:0] held_angle [4];
    logic [7:0]  held_flags;
    logic [31:0] good_total;
    logic [31:0] bad_total;
    logic [7:0]  marker;
    logic [7:0]  kind;

    t_status_result expected_status_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_good_seen  = 0;
        o_bad_seen   = 0;
    end

    task automatic parse_byte(input logic [7:0] b);
        t_status_result r;
        int idx;
        logic ok;
        case (phase)
            PH_START: begin
                if (b == marker) begin
                    crc_acc = crc8_step(CRC_INIT, b);
                    phase   = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b == kind) begin
                    crc_acc = crc8_step(crc_acc, b);
                    pos     = 5'd2;
                    phase   = PH_PAYLOAD;
                end else begin
                    phase = PH_START;
                end
            end
            PH_PAYLOAD: begin
                idx = int'(pos) - 2;
                if (pos >= 5'd2 && idx < PAYLOAD_LEN) frame_store[idx] = b;
                crc_acc = crc8_step(crc_acc, b);
                pos     = pos + 5'd1;
                if (pos >= FRAME_BYTES - 1) phase = PH_CRC;
            end
            default: begin
                ok = (b == crc_acc);
                if (ok) begin
                    for (int k = 0; k < 4; k++) begin
                        held_angle[k] = {frame_store[4*k+3], frame_store[4*k+2],
                                         frame_store[4*k+1], frame_store[4*k]};
                    end
                    held_flags = frame_store[PAYLOAD_LEN-1];
                    good_total = good_total + 32'd1;
                end else begin
                    bad_total = bad_total + 32'd1;
                end
                phase = PH_START;
                pos   = 5'd0;
                r = {ok, held_angle[0], held_angle[1], held_angle[2], held_angle[3],
                     held_flags, good_total, bad_total};
                expected_status_q.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (o_fail_count < MAX_REPORTS)
                $display("[%0t] %s mismatch on result %0d: expected %h, got %h",
                         $realtime, field, o_results, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_status(input t_status_result got);
        t_status_result want;
        if (expected_status_q.size() == 0) begin
            if (o_fail_count < MAX_REPORTS)
                $display("[%0t] result transfer with nothing expected: %h", $realtime, got);
            o_fail_count++;
        end else begin
            want = expected_status_q.pop_front();
            check_field("frame_ok",    32'(want.frame_ok), 32'(got.frame_ok));
            check_field("front_left",  want.front_left,    got.front_left);
            check_field("front_right", want.front_right,   got.front_right);
            check_field("rear_left",   want.rear_left,     got.rear_left);
            check_field("rear_right",  want.rear_right,    got.rear_right);
            check_field("flags",       32'(want.flags),    32'(got.flags));
            check_field("good_frames", want.good_frames,   got.good_frames);
            check_field("bad_frames",  want.bad_frames,    got.bad_frames);
        end
        o_results++;
        if (got.frame_ok === 1'b1) o_good_seen++;
        else o_bad_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_START;
            pos        = 5'd0;
            crc_acc    = CRC_INIT;
            held_flags = 8'd0;
            good_total = 32'd0;
            bad_total  = 32'd0;
            marker     = START_MARKER_RST;
            kind       = STATUS_KIND_RST;
            for (int k = 0; k < 4; k++) held_angle[k] = 32'd0;
            expected_status_q.delete();
        end else begin
            // result first, so a result leaving this edge never meets an
            // expectation made by a byte taken at the same edge
            if (i_out_valid && i_out_ready)
                check_status({i_frame_ok, i_front_left_word, i_front_right_word,
                              i_rear_left_word, i_rear_right_word, i_status_flags,
                              i_good_frames, i_bad_frames});
            // a byte taken at the same edge as a register write still sees
            // the old register value
            if (i_in_valid && i_in_ready) parse_byte(i_rx_byte);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START_MARKER) marker = i_cfg_data;
                else if (i_cfg_index == CFG_STATUS_KIND) kind = i_cfg_data;
            end
        end
        o_pending = expected_status_q.size();
    end

endmodule

>>> test/tb_crc8_status_frame_receiver_core.sv
// Testbench top for the CRC-8 status frame receiver: stimulus, idling and the verdict.
`timescale 1ns / 1ps

// Drives byte streams into the receiver and lets the checker predict and
// compare every result transfer. A short directed part hits field extremes,
// a wrong type byte equal to the start marker, start values inside a frame
// and a CRC failure. Then four register settings follow (extremes among
// them, plus writes to unused indexes), each with random traffic: mostly
// well-formed frames with random content and some bad CRCs, the rest noise,
// aborted and truncated frames. One phase runs with no idling at all; in
// another the receiver holds off long enough that the output slot fills and
// the block stalls its byte input.

module tb_crc8_status_frame_receiver_core;

    import crc8sr_pkg::*;
    import crc8sr_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 100;
    localparam int RESULTS_PER_PH = 4;
    localparam int IDLE_PCT       = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_rx_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_frame_ok;
    logic [31:0]          o_front_left_word;
    logic [31:0]          o_front_right_word;
    logic [31:0]          o_rear_left_word;
    logic [31:0]          o_rear_right_word;
    logic [7:0]           o_status_flags;
    logic [31:0]          o_good_frames;
    logic [31:0]          o_bad_frames;

    int fail_count;
    int pending;
    int results;
    int good_seen;
    int bad_seen;

    // stimulus bookkeeping
    int          idle_pct   = IDLE_PCT;
    bit          hold_req   = 1'b0;
    int          bytes_sent = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;
    logic [7:0]  cur_marker = START_MARKER_RST;
    logic [7:0]  cur_kind   = STATUS_KIND_RST;

    crc8_status_frame_receiver_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_frame_ok         (o_frame_ok),
        .o_front_left_word  (o_front_left_word),
        .o_front_right_word (o_front_right_word),
        .o_rear_left_word   (o_rear_left_word),
        .o_rear_right_word  (o_rear_right_word),
        .o_status_flags     (o_status_flags),
        .o_good_frames      (o_good_frames),
        .o_bad_frames       (o_bad_frames)
    );

    crc8_status_frame_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_rx_byte          (i_rx_byte),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_frame_ok         (o_frame_ok),
        .i_front_left_word  (o_front_left_word),
        .i_front_right_word (o_front_right_word),
        .i_rear_left_word   (o_rear_left_word),
        .i_rear_right_word  (o_rear_right_word),
        .i_status_flags     (o_status_flags),
        .i_good_frames      (o_good_frames),
        .i_bad_frames       (o_bad_frames),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_results          (results),
        .o_good_seen        (good_seen),
        .o_bad_seen         (bad_seen)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request. The
    // hold-off counts its own cycles so the sender keeps pushing meanwhile.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // One byte transfer. Called at a falling edge, returns at a falling edge
    // with valid still high, so back-to-back bytes never drop valid.
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
        if (idx == CFG_START_MARKER) cur_marker = data;
        else if (idx == CFG_STATUS_KIND) cur_kind = data;
    endtask

    // Let every owed result drain, then a few more cycles for bytes that
    // make no result.
    task automatic drain_results();
        i_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // body: 17 bytes, byte i at [8*i +: 8]; angles land little-endian
    task automatic send_frame(input logic [8*PAYLOAD_LEN-1:0] body, input bit spoil_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc8_step(CRC_INIT, cur_marker);
        put_byte(cur_marker);
        crc = crc8_step(crc, cur_kind);
        put_byte(cur_kind);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            b   = body[8*i +: 8];
            crc = crc8_step(crc, b);
            put_byte(b);
        end
        if (spoil_crc) crc = crc ^ 8'($urandom_range(1, 255));
        put_byte(crc);
    endtask

    // random payload, sprinkled with start markers
    function automatic logic [8*PAYLOAD_LEN-1:0] random_body();
        logic [8*PAYLOAD_LEN-1:0] body;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            body[8*i +: 8] = ($urandom_range(4) == 0) ? cur_marker : 8'($urandom_range(255));
        end
        return body;
    endfunction

    // One chunk of random traffic; mostly well-formed frames.
    task automatic random_chunk();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 70) begin
            send_frame(random_body(), $urandom_range(4) == 0);
        end else if (roll < 80) begin
            // aborted: wrong type byte right after the start marker
            put_byte(cur_marker);
            put_byte(cur_kind ^ 8'($urandom_range(1, 255)));
        end else if (roll < 88) begin
            // truncated frame; the parser swallows what follows as payload
            put_byte(cur_marker);
            put_byte(cur_kind);
            n = $urandom_range(1, 12);
            repeat (n) put_byte(8'($urandom_range(255)));
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) put_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int          phase_start;
        logic [7:0]  set_marker;
        logic [7:0]  set_kind;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = 8'h00;
        i_valid     = 1'b0;
        i_rx_byte   = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset register values. Noise and a lone type byte first.
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(cur_kind);
        // Wrong type that equals the start marker: it must not reopen a
        // frame, so the following type byte is just noise.
        put_byte(cur_marker);
        put_byte(cur_marker);
        put_byte(cur_kind);
        // Good frame: extreme angles, start values inside the payload.
        send_frame({8'hFF, 32'h02AA_0155, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0);
        // Bad CRC: status must stay at the last good frame.
        send_frame('0, 1'b1);
        drain_results();

        // Random traffic over several register settings.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin set_marker = 8'h00; set_kind = 8'hFF; end
                1: begin set_marker = 8'hFF; set_kind = 8'h00; end
                default: begin
                    set_marker = 8'($urandom_range(255));
                    set_kind   = 8'($urandom_range(255));
                end
            endcase
            cfg_write(CFG_START_MARKER, set_marker);
            cfg_write(CFG_STATUS_KIND, set_kind);
            // unused index: must be ignored
            cfg_write((p == 0) ? CFG_UNUSED_TOP : CFG_IDX_W'($urandom_range(2, 255)),
                      8'($urandom_range(255)));

            idle_pct = (p == 2) ? 0 : IDLE_PCT;
            if (p == 1) begin
                // receiver holds off while frames keep coming
                hold_req = 1'b1;
                repeat (3) send_frame(random_body(), 1'b0);
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES || results < RESULTS_PER_PH * (p + 1))
                random_chunk();
            drain_results();
        end

        $display("Covered %0d byte transfers and %0d register writes over five settings,",
                 bytes_sent, cfg_writes);
        $display("including a long receiver stall; %0d results: %0d good, %0d bad frames.",
                 results, good_seen, bad_seen);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> crc8_status_frame_receiver_core.f
src/crc8sr_pkg.sv
src/crc8sr_parser.sv
src/crc8sr_status.sv
src/crc8_status_frame_receiver_core.sv
test/crc8_status_frame_checker.sv
test/tb_crc8_status_frame_receiver_core.sv
